@@ design/xoroshiro_random_index_unit_defines.svh @@
// assertion macros used by xoroshiro_random_index_unit
`ifndef XOROSHIRO_RANDOM_INDEX_UNIT_DEFINES_SVH
`define XOROSHIRO_RANDOM_INDEX_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define XRI_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("xri assertion failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define XRI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("xri assertion failed");

`endif

@@ design/xri_pkg.sv @@
`default_nettype none

package xri_pkg;

  // splitmix64 constants
  localparam logic [63:0] GoldenStep = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MixMulA    = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MixMulB    = 64'h94D049BB133111EB;

  localparam int unsigned MixShiftA = 30;
  localparam int unsigned MixShiftB = 27;
  localparam int unsigned MixShiftC = 31;

  // xoroshiro128+ rotations and shift
  localparam int unsigned RotA  = 55;
  localparam int unsigned ShB   = 14;
  localparam int unsigned RotC  = 36;

  // splitmix64 of seed zero, first and second output
  localparam logic [63:0] ResetStateLow  = 64'hE220A8397B1DCDAF;
  localparam logic [63:0] ResetStateHigh = 64'h6E789E6AA1B965F4;

  localparam int unsigned BoundWidthDefault = 16;
  localparam int unsigned BoundPortWidth    = 16;
  localparam int unsigned IndexWidth        = 16;
  localparam int unsigned WordWidth         = 64;

  typedef enum logic {
    FUNC_RESEED = 1'b0,
    FUNC_DRAW   = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX_XOR,
    ST_MUL_LL,
    ST_MUL_LH,
    ST_MUL_HL,
    ST_MIX_END,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

@@ design/xoroshiro_random_index_unit.sv @@
// channel | direction | handshake               | payload
// --------+-----------+-------------------------+----------------------------
// in      | input     | in_valid_i / in_ready_o | func_i, seed_i, bound_i
// out     | output    | out_valid_o/out_ready_i | index_o, raw_value_o
//
// one word in flight; in_ready_o is high only while the sequencer is idle
// reseed: two splitmix64 outputs, each from two mix rounds on one shared 32x32 multiplier
// draw with bound of two or more: runs the radix-2 remainder loop (64 steps)
// draw with bound below two: state left as is
// a finished result sits in the output register, so a stalled out side only
// holds the sequencer in its last step; reset loads the seed-zero generator state
`default_nettype none

`include "xoroshiro_random_index_unit_defines.svh"

module xoroshiro_random_index_unit #(
  parameter int unsigned BoundWidth = xri_pkg::BoundWidthDefault
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                func_i,
  input  wire logic [xri_pkg::WordWidth-1:0]       seed_i,
  input  wire logic [xri_pkg::BoundPortWidth-1:0]  bound_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [xri_pkg::IndexWidth-1:0]           index_o,
  output logic [xri_pkg::WordWidth-1:0]            raw_value_o
);

  // only the low min(BoundWidth, 16) bits of the bound are used; the port has 16
  localparam int unsigned EffW =
    (BoundWidth < xri_pkg::BoundPortWidth) ? BoundWidth : xri_pkg::BoundPortWidth;
  localparam int unsigned W = xri_pkg::WordWidth;
  localparam int unsigned CntW = $clog2(W);

  xri_pkg::state_e state_q, state_d;

  logic            round_q, round_d;   // 0: shift 30 / mul A, 1: shift 27 / mul B
  logic            word_q, word_d;     // 0: filling state_low, 1: state_high
  logic [CntW-1:0] cnt_q, cnt_d;       // dividend bit position
  logic            out_valid_q, out_valid_d;

  logic [W-1:0] s0_q, s0_d;            // state_low
  logic [W-1:0] s1_q, s1_d;            // state_high

  logic [W-1:0]    acc_q, acc_d;       // splitmix seed accumulator
  logic [W-1:0]    z_q, z_d;           // splitmix working value
  logic [W-1:0]    prod_q, prod_d;     // partial product sum
  logic [W-1:0]    raw_q, raw_d;       // raw sum, also the dividend
  logic [EffW-1:0] rem_q, rem_d;
  logic [EffW-1:0] bound_q, bound_d;
  logic [xri_pkg::IndexWidth-1:0] index_q, index_d;
  logic [W-1:0]    raw_out_q, raw_out_d;

  logic in_fire;
  logic is_draw;
  logic bound_ok;
  logic out_free;
  logic [EffW-1:0] bound_eff;

  assign in_ready_o = (state_q == xri_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_draw    = (func_i == xri_pkg::FUNC_DRAW);
  assign bound_eff  = bound_i[EffW-1:0];
  assign bound_ok   = |bound_eff[EffW-1:1];
  assign out_free   = !out_valid_q || out_ready_i;

  // xoroshiro128+ step
  logic [W-1:0] x_mix;
  logic [W-1:0] s0_adv;
  logic [W-1:0] s1_adv;

  assign x_mix  = s0_q ^ s1_q;
  assign s0_adv = ((s0_q << xri_pkg::RotA) | (s0_q >> (W - xri_pkg::RotA)))
                  ^ x_mix ^ (x_mix << xri_pkg::ShB);
  assign s1_adv = (x_mix << xri_pkg::RotC) | (x_mix >> (W - xri_pkg::RotC));

  // shared 32x32 multiplier: low 64 bits of z * const from three partial products
  logic [W-1:0]   mul_const;
  logic [W/2-1:0] mul_a;
  logic [W/2-1:0] mul_b;
  logic [W-1:0]   mul_p;

  assign mul_const = round_q ? xri_pkg::MixMulB : xri_pkg::MixMulA;

  always_comb begin
    case (state_q)
      xri_pkg::ST_MUL_LL: begin
        mul_a = z_q[W/2-1:0];
        mul_b = mul_const[W/2-1:0];
      end
      xri_pkg::ST_MUL_LH: begin
        mul_a = z_q[W/2-1:0];
        mul_b = mul_const[W-1:W/2];
      end
      default: begin
        mul_a = z_q[W-1:W/2];
        mul_b = mul_const[W/2-1:0];
      end
    endcase
  end

  assign mul_p = W'(mul_a) * W'(mul_b);

  // shared xor-shift for the mixer
  logic [W-1:0] mix_sh;
  logic [W-1:0] mix_fin;

  assign mix_sh  = round_q ? (z_q >> xri_pkg::MixShiftB) : (z_q >> xri_pkg::MixShiftA);
  assign mix_fin = z_q ^ (z_q >> xri_pkg::MixShiftC);

  // one restoring remainder step
  logic [EffW:0] rem_sh;
  logic [EffW:0] rem_sub;
  logic          rem_ge;
  logic [EffW-1:0] rem_next;

  assign rem_sh   = {rem_q, raw_q[cnt_q]};
  assign rem_sub  = rem_sh - {1'b0, bound_q};
  assign rem_ge   = (rem_sh >= {1'b0, bound_q});
  assign rem_next = rem_ge ? rem_sub[EffW-1:0] : rem_sh[EffW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      xri_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (!is_draw) begin
            state_d = xri_pkg::ST_MIX_XOR;
          end else if (bound_ok) begin
            state_d = xri_pkg::ST_DIV;
          end else begin
            state_d = xri_pkg::ST_DONE;
          end
        end
      end
      xri_pkg::ST_MIX_XOR: state_d = xri_pkg::ST_MUL_LL;
      xri_pkg::ST_MUL_LL:  state_d = xri_pkg::ST_MUL_LH;
      xri_pkg::ST_MUL_LH:  state_d = xri_pkg::ST_MUL_HL;
      xri_pkg::ST_MUL_HL: begin
        state_d = round_q ? xri_pkg::ST_MIX_END : xri_pkg::ST_MIX_XOR;
      end
      xri_pkg::ST_MIX_END: begin
        state_d = word_q ? xri_pkg::ST_DONE : xri_pkg::ST_MIX_XOR;
      end
      xri_pkg::ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = xri_pkg::ST_DONE;
        end
      end
      xri_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = xri_pkg::ST_IDLE;
        end
      end
      default: state_d = xri_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    round_d     = round_q;
    word_d      = word_q;
    cnt_d       = cnt_q;
    s0_d        = s0_q;
    s1_d        = s1_q;
    acc_d       = acc_q;
    z_d         = z_q;
    prod_d      = prod_q;
    raw_d       = raw_q;
    rem_d       = rem_q;
    bound_d     = bound_q;
    index_d     = index_q;
    raw_out_d   = raw_out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      xri_pkg::ST_IDLE: begin
        if (in_fire) begin
          raw_d = '0;
          rem_d = '0;
          if (!is_draw) begin
            acc_d   = seed_i + xri_pkg::GoldenStep;
            z_d     = seed_i + xri_pkg::GoldenStep;
            round_d = 1'b0;
            word_d  = 1'b0;
          end else if (bound_ok) begin
            raw_d   = s0_q + s1_q;
            s0_d    = s0_adv;
            s1_d    = s1_adv;
            bound_d = bound_eff;
            cnt_d   = CntW'(W - 1);
          end
        end
      end
      xri_pkg::ST_MIX_XOR: z_d = z_q ^ mix_sh;
      xri_pkg::ST_MUL_LL:  prod_d = mul_p;
      xri_pkg::ST_MUL_LH:  prod_d = prod_q + {mul_p[W/2-1:0], (W/2)'(0)};
      xri_pkg::ST_MUL_HL: begin
        z_d     = prod_q + {mul_p[W/2-1:0], (W/2)'(0)};
        round_d = !round_q;
      end
      xri_pkg::ST_MIX_END: begin
        if (!word_q) begin
          s0_d   = mix_fin;
          acc_d  = acc_q + xri_pkg::GoldenStep;
          z_d    = acc_q + xri_pkg::GoldenStep;
          word_d = 1'b1;
        end else begin
          s1_d = mix_fin;
        end
      end
      xri_pkg::ST_DIV: begin
        rem_d = rem_next;
        cnt_d = cnt_q - 1'b1;
      end
      xri_pkg::ST_DONE: begin
        if (out_free) begin
          index_d     = xri_pkg::IndexWidth'(rem_q);
          raw_out_d   = raw_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= xri_pkg::ST_IDLE;
      round_q     <= 1'b0;
      word_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      s0_q        <= xri_pkg::ResetStateLow;
      s1_q        <= xri_pkg::ResetStateHigh;
    end else begin
      state_q     <= state_d;
      round_q     <= round_d;
      word_q      <= word_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      s0_q        <= s0_d;
      s1_q        <= s1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    z_q       <= z_d;
    prod_q    <= prod_d;
    raw_q     <= raw_d;
    rem_q     <= rem_d;
    bound_q   <= bound_d;
    index_q   <= index_d;
    raw_out_q <= raw_out_d;
  end

  assign out_valid_o = out_valid_q;
  assign index_o     = index_q;
  assign raw_value_o = raw_out_q;

  // remainder always stays below the divisor during the loop
  `XRI_ASSERT_SAME(a_rem_below_bound, state_q == xri_pkg::ST_DIV, rem_q < bound_q)
  // an accepted word makes the block busy
  `XRI_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready_o)
  // a free output slot in the last step always yields a result
  `XRI_ASSERT_NEXT(a_done_loads, state_q == xri_pkg::ST_DONE && out_free, out_valid_o)
  // a taken result with nothing new behind it leaves the output empty
  `XRI_ASSERT_NEXT(a_out_drains, out_valid_o && out_ready_i && state_q != xri_pkg::ST_DONE,
                   !out_valid_o)

endmodule

`default_nettype wire
